// ===== sv/sgss_pkg.sv =====
// Shared constants, codes and state type for the sort / gcd / search / select engine.
`default_nettype none
package sgss_pkg;
   localparam int MAX_ITEMS = 32;
   localparam int IDX_W     = $clog2(MAX_ITEMS);
   localparam int CNT_W     = IDX_W + 1;
   localparam int VAL_W     = 16;
   localparam int RANK_W    = 8;
   localparam int REQ_W     = 48;
   localparam int RSP_W     = 56;

   typedef enum logic [1:0] {
      ACT_LOAD   = 2'd0,
      ACT_SEARCH = 2'd1,
      ACT_SELECT = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SORT_RD,
      S_SORT_LD,
      S_SORT_SCAN,
      S_SORT_WR,
      S_GCD,
      S_EMIT_RD,
      S_EMIT_LD,
      S_EMIT_DIV,
      S_EMIT_OUT,
      S_SRCH,
      S_SRCH_OUT,
      S_SEL_RD,
      S_SEL_OUT
   } state_type;
endpackage
`default_nettype wire

// ===== sv/sort_gcd_search_select_engine.sv =====
// Top level: weight store, rank sort, binary gcd, divider and result register.
// A plain load writes one word while the store has room; a select reads the sorted
//   store into the result register; a search scans every stored word. A final load
//   runs the set: per element i a rank pass (read, load, scan, write) and a binary gcd,
//   then per element an emit (read, load, 16-step division, output), whose output step
//   waits while rsp_tready is low. The single read port of the original store sets the
//   scan lengths. One word in work at a time; req_tready is high only when idle.
//   Synchronous active-high reset clears control state.
`default_nettype none
module sort_gcd_search_select_engine (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // req_tdata: action[1:0], weight_value[17:2], search_key[33:18], rank[41:34], 0 pad
   input  wire logic [sgss_pkg::REQ_W-1:0] req_tdata,
   input  wire logic                       req_tlast,   // final_load
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   // rsp_tdata: sorted_value[15:0], bar_length[31:16], found[32],
   //            selected_value[48:33], rank_valid[49], 0 pad
   output logic [sgss_pkg::RSP_W-1:0]      rsp_tdata,
   output logic                            rsp_tlast,   // end_of_run
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready
);

   localparam int IW = sgss_pkg::IDX_W;
   localparam int CW = sgss_pkg::CNT_W;
   localparam int VW = sgss_pkg::VAL_W;

   sgss_pkg::state_type  state_ff, state_in;
   sgss_pkg::action_type act;

   logic [VW-1:0]               f_weight, f_key;
   logic [sgss_pkg::RANK_W-1:0] f_rank, rank_m1;
   logic                        acc, out_free, scan_done, gcd_done, last_elem;

   // set state
   logic [CW-1:0] count_ff, count_in, base_cnt;
   logic          complete_ff, complete_in;
   logic [VW-1:0] gcd_ff, gcd_in;

   // sequencing
   logic [CW-1:0] i_ff, i_in, j_ff, j_in, jd_ff, jd_in, rank_ff, rank_in;
   logic          dv_ff, dv_in;
   logic [VW-1:0] vi_ff, vi_in, key_ff, key_in, sv_ff, sv_in;
   logic          hit_ff, hit_in, selok_ff, selok_in;
   logic [IW-1:0] seladdr_ff, seladdr_in;

   // gcd unit
   logic [VW-1:0] ga_ff, ga_in, gb_ff, gb_in, g_res;
   logic [3:0]    gk_ff, gk_in;

   // divider
   logic [VW-1:0] dq_ff, dq_in;
   logic [VW:0]   dr_ff, dr_in, d_try;
   logic [4:0]    dcnt_ff, dcnt_in;

   // result register
   logic          o_valid_ff, o_valid_in, o_found_ff, o_found_in, o_rv_ff, o_rv_in;
   logic          o_last_ff, o_last_in;
   logic [VW-1:0] o_sv_ff, o_sv_in, o_bar_ff, o_bar_in, o_sel_ff, o_sel_in;

   // memories
   logic [VW-1:0] orig_mem [sgss_pkg::MAX_ITEMS];
   logic [VW-1:0] sort_mem [sgss_pkg::MAX_ITEMS];
   logic          orig_we, orig_re, sort_we, sort_re;
   logic [IW-1:0] orig_waddr, orig_raddr, sort_waddr, sort_raddr;
   logic [VW-1:0] orig_wdata, sort_wdata, orig_rdata_ff, sort_rdata_ff;

   assign act      = sgss_pkg::action_type'(req_tdata[1:0]);
   assign f_weight = req_tdata[17:2];
   assign f_key    = req_tdata[33:18];
   assign f_rank   = req_tdata[41:34];
   assign rank_m1  = f_rank - 8'd1;

   assign req_tready = (state_ff == sgss_pkg::S_IDLE);
   assign acc        = req_tvalid && req_tready;
   assign out_free   = !o_valid_ff || rsp_tready;
   assign scan_done  = (j_ff == count_ff) && !dv_ff;
   assign gcd_done   = (ga_ff == '0) || (gb_ff == '0);
   assign g_res      = (ga_ff == '0) ? (gb_ff << gk_ff) : (ga_ff << gk_ff);
   assign last_elem  = (i_ff + CW'(1)) == count_ff;
   assign base_cnt   = complete_ff ? '0 : count_ff;
   assign d_try      = {dr_ff[VW-1:0], dq_ff[VW-1]};

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tlast  = o_last_ff;
   assign rsp_tdata  = {6'd0, o_rv_ff, o_sel_ff, o_found_ff, o_bar_ff, o_sv_ff};

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sgss_pkg::S_IDLE: begin
            if (acc) begin
               unique case (act)
                  sgss_pkg::ACT_LOAD:   state_in = req_tlast ? sgss_pkg::S_SORT_RD
                                                             : sgss_pkg::S_IDLE;
                  sgss_pkg::ACT_SEARCH: state_in = sgss_pkg::S_SRCH;
                  sgss_pkg::ACT_SELECT: state_in = sgss_pkg::S_SEL_RD;
                  default:              state_in = sgss_pkg::S_IDLE;
               endcase
            end
         end
         sgss_pkg::S_SORT_RD:   state_in = sgss_pkg::S_SORT_LD;
         sgss_pkg::S_SORT_LD:   state_in = sgss_pkg::S_SORT_SCAN;
         sgss_pkg::S_SORT_SCAN: if (scan_done) state_in = sgss_pkg::S_SORT_WR;
         sgss_pkg::S_SORT_WR:   state_in = sgss_pkg::S_GCD;
         sgss_pkg::S_GCD: begin
            if (gcd_done) state_in = last_elem ? sgss_pkg::S_EMIT_RD : sgss_pkg::S_SORT_RD;
         end
         sgss_pkg::S_EMIT_RD:   state_in = sgss_pkg::S_EMIT_LD;
         sgss_pkg::S_EMIT_LD:   state_in = sgss_pkg::S_EMIT_DIV;
         sgss_pkg::S_EMIT_DIV:  if (dcnt_ff == '0) state_in = sgss_pkg::S_EMIT_OUT;
         sgss_pkg::S_EMIT_OUT: begin
            if (out_free) state_in = last_elem ? sgss_pkg::S_IDLE : sgss_pkg::S_EMIT_RD;
         end
         sgss_pkg::S_SRCH:      if (scan_done) state_in = sgss_pkg::S_SRCH_OUT;
         sgss_pkg::S_SRCH_OUT:  if (out_free) state_in = sgss_pkg::S_IDLE;
         sgss_pkg::S_SEL_RD:    state_in = sgss_pkg::S_SEL_OUT;
         sgss_pkg::S_SEL_OUT:   if (out_free) state_in = sgss_pkg::S_IDLE;
         default:               state_in = sgss_pkg::S_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      count_in = count_ff;  complete_in = complete_ff;  gcd_in = gcd_ff;
      i_in = i_ff;  j_in = j_ff;  jd_in = jd_ff;  dv_in = 1'b0;  rank_in = rank_ff;
      vi_in = vi_ff;  key_in = key_ff;  sv_in = sv_ff;  hit_in = hit_ff;
      selok_in = selok_ff;  seladdr_in = seladdr_ff;
      ga_in = ga_ff;  gb_in = gb_ff;  gk_in = gk_ff;
      dq_in = dq_ff;  dr_in = dr_ff;  dcnt_in = dcnt_ff;
      o_valid_in = o_valid_ff && !rsp_tready;
      o_sv_in = o_sv_ff;  o_bar_in = o_bar_ff;  o_found_in = o_found_ff;
      o_sel_in = o_sel_ff;  o_rv_in = o_rv_ff;  o_last_in = o_last_ff;
      orig_we = 1'b0;  orig_waddr = base_cnt[IW-1:0];  orig_wdata = f_weight;
      orig_re = 1'b0;  orig_raddr = j_ff[IW-1:0];
      sort_we = 1'b0;  sort_waddr = rank_ff[IW-1:0];  sort_wdata = vi_ff;
      sort_re = 1'b0;  sort_raddr = i_ff[IW-1:0];

      unique case (state_ff)
         sgss_pkg::S_IDLE: begin
            if (acc) begin
               unique case (act)
                  sgss_pkg::ACT_LOAD: begin
                     complete_in = req_tlast;
                     count_in    = base_cnt;
                     if (base_cnt < CW'(sgss_pkg::MAX_ITEMS)) begin
                        orig_we  = 1'b1;
                        count_in = base_cnt + CW'(1);
                     end
                     gcd_in = '0;
                     i_in   = '0;
                  end
                  sgss_pkg::ACT_SEARCH: begin
                     key_in = f_key;
                     hit_in = 1'b0;
                     j_in   = '0;
                  end
                  sgss_pkg::ACT_SELECT: begin
                     selok_in   = complete_ff && (f_rank != '0) &&
                                  (f_rank <= sgss_pkg::RANK_W'(count_ff));
                     seladdr_in = rank_m1[IW-1:0];
                  end
                  default: ;
               endcase
            end
         end
         sgss_pkg::S_SORT_RD: begin
            orig_re    = 1'b1;
            orig_raddr = i_ff[IW-1:0];
         end
         sgss_pkg::S_SORT_LD: begin
            vi_in   = orig_rdata_ff;
            j_in    = '0;
            rank_in = '0;
         end
         sgss_pkg::S_SORT_SCAN, sgss_pkg::S_SRCH: begin
            if (j_ff != count_ff) begin
               orig_re = 1'b1;
               dv_in   = 1'b1;
               jd_in   = j_ff;
               j_in    = j_ff + CW'(1);
            end
            if (dv_ff) begin
               // stable rank: smaller values, plus equal values stored earlier
               if ((orig_rdata_ff < vi_ff) || ((orig_rdata_ff == vi_ff) && (jd_ff < i_ff)))
                  rank_in = rank_ff + CW'(1);
               if (orig_rdata_ff == key_ff) hit_in = 1'b1;
            end
         end
         sgss_pkg::S_SORT_WR: begin
            sort_we = 1'b1;
            ga_in   = gcd_ff;
            gb_in   = vi_ff;
            gk_in   = '0;
         end
         sgss_pkg::S_GCD: begin
            if (gcd_done) begin
               gcd_in = g_res;
               i_in   = last_elem ? '0 : i_ff + CW'(1);
            end else if (!ga_ff[0] && !gb_ff[0]) begin
               ga_in = ga_ff >> 1;
               gb_in = gb_ff >> 1;
               gk_in = gk_ff + 4'd1;
            end else if (!ga_ff[0]) begin
               ga_in = ga_ff >> 1;
            end else if (!gb_ff[0]) begin
               gb_in = gb_ff >> 1;
            end else if (ga_ff >= gb_ff) begin
               ga_in = ga_ff - gb_ff;
            end else begin
               gb_in = gb_ff - ga_ff;
            end
         end
         sgss_pkg::S_EMIT_RD: begin
            orig_re    = 1'b1;
            orig_raddr = i_ff[IW-1:0];
            sort_re    = 1'b1;
         end
         sgss_pkg::S_EMIT_LD: begin
            sv_in   = sort_rdata_ff;
            dq_in   = orig_rdata_ff;
            dr_in   = '0;
            dcnt_in = 5'd16;
         end
         sgss_pkg::S_EMIT_DIV: begin
            // restoring division, one quotient bit a cycle
            if (dcnt_ff != '0) begin
               if (d_try >= {1'b0, gcd_ff}) begin
                  dr_in = d_try - {1'b0, gcd_ff};
                  dq_in = {dq_ff[VW-2:0], 1'b1};
               end else begin
                  dr_in = d_try;
                  dq_in = {dq_ff[VW-2:0], 1'b0};
               end
               dcnt_in = dcnt_ff - 5'd1;
            end
         end
         sgss_pkg::S_EMIT_OUT: begin
            if (out_free) begin
               o_valid_in = 1'b1;
               o_sv_in    = sv_ff;
               o_bar_in   = (gcd_ff == '0) ? '0 : dq_ff;
               o_found_in = 1'b0;
               o_sel_in   = '0;
               o_rv_in    = 1'b0;
               o_last_in  = last_elem;
               i_in       = i_ff + CW'(1);
            end
         end
         sgss_pkg::S_SRCH_OUT: begin
            if (out_free) begin
               o_valid_in = 1'b1;
               o_sv_in    = '0;
               o_bar_in   = '0;
               o_found_in = hit_ff;
               o_sel_in   = '0;
               o_rv_in    = 1'b0;
               o_last_in  = 1'b1;
            end
         end
         sgss_pkg::S_SEL_RD: begin
            sort_re    = selok_ff;
            sort_raddr = seladdr_ff;
         end
         sgss_pkg::S_SEL_OUT: begin
            if (out_free) begin
               o_valid_in = 1'b1;
               o_sv_in    = '0;
               o_bar_in   = '0;
               o_found_in = 1'b0;
               o_sel_in   = selok_ff ? sort_rdata_ff : '0;
               o_rv_in    = selok_ff;
               o_last_in  = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Original and sorted stores, one write and one registered read each
   always_ff @(posedge clock) begin
      if (orig_we) orig_mem[orig_waddr] <= orig_wdata;
      if (orig_re) orig_rdata_ff <= orig_mem[orig_raddr];
   end

   always_ff @(posedge clock) begin
      if (sort_we) sort_mem[sort_waddr] <= sort_wdata;
      if (sort_re) sort_rdata_ff <= sort_mem[sort_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= sgss_pkg::S_IDLE;
         count_ff    <= '0;
         complete_ff <= 1'b0;
         gcd_ff      <= '0;
         dv_ff       <= 1'b0;
         o_valid_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         complete_ff <= complete_in;
         gcd_ff      <= gcd_in;
         dv_ff       <= dv_in;
         o_valid_ff  <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;  j_ff <= j_in;  jd_ff <= jd_in;  rank_ff <= rank_in;
      vi_ff <= vi_in;  key_ff <= key_in;  sv_ff <= sv_in;  hit_ff <= hit_in;
      selok_ff <= selok_in;  seladdr_ff <= seladdr_in;
      ga_ff <= ga_in;  gb_ff <= gb_in;  gk_ff <= gk_in;
      dq_ff <= dq_in;  dr_ff <= dr_in;  dcnt_ff <= dcnt_in;
      o_sv_ff <= o_sv_in;  o_bar_ff <= o_bar_in;  o_found_ff <= o_found_in;
      o_sel_ff <= o_sel_in;  o_rv_ff <= o_rv_in;  o_last_ff <= o_last_in;
   end

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(sgss_pkg::MAX_ITEMS))
      else $error("element count above capacity");

   a_sort_rank: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sgss_pkg::S_SORT_WR) |-> (rank_ff < count_ff))
      else $error("sort rank outside stored set");

   a_emit_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sgss_pkg::S_EMIT_OUT) |-> (i_ff < count_ff))
      else $error("emit index outside stored set");

endmodule
`default_nettype wire
